/* sv/bamrsd_pkg.sv */
`default_nettype none

package bamrsd_pkg;

  localparam logic [2:0] KIND_HDR  = 3'd0;
  localparam logic [2:0] KIND_NAME = 3'd1;
  localparam logic [2:0] KIND_BASE = 3'd2;
  localparam logic [2:0] KIND_QUAL = 3'd3;
  localparam logic [2:0] KIND_DONE = 3'd4;
  localparam logic [2:0] KIND_END  = 3'd5;
  localparam logic [2:0] KIND_ERR  = 3'd6;

  localparam logic [15:0] FLAG_DROP_MASK = 16'h0900;
  localparam logic [7:0]  QUAL_MISSING   = 8'hff;
  localparam logic [7:0]  QUAL_OFFSET    = 8'd33;

  typedef struct packed {
    logic [2:0]  kind;
    logic [30:0] position;
    logic [7:0]  char_value;
    logic [15:0] flag;
    logic [30:0] seq_len;
    logic        paired;
    logic        last;
  } result_t;

  // 4-bit base code to its ASCII letter
  function automatic logic [7:0] base_letter(input logic [3:0] code);
    logic [7:0] c;
    case (code)
      4'd0:    c = 8'h3d; // =
      4'd1:    c = 8'h41; // A
      4'd2:    c = 8'h43; // C
      4'd3:    c = 8'h4d; // M
      4'd4:    c = 8'h47; // G
      4'd5:    c = 8'h52; // R
      4'd6:    c = 8'h53; // S
      4'd7:    c = 8'h56; // V
      4'd8:    c = 8'h54; // T
      4'd9:    c = 8'h57; // W
      4'd10:   c = 8'h59; // Y
      4'd11:   c = 8'h48; // H
      4'd12:   c = 8'h4b; // K
      4'd13:   c = 8'h44; // D
      4'd14:   c = 8'h42; // B
      default: c = 8'h4e; // N
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/bamrsd_out_fifo.sv */
`default_nettype none

module bamrsd_out_fifo
  import bamrsd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic [1:0] push_count,
  input  wire result_t push0,
  input  wire result_t push1,
  output logic         room2,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  result_t    mem [4];
  logic [1:0] head;
  logic [1:0] tail;
  logic [2:0] count;
  logic       pop;

  assign room2     = (count < 3'd3);
  assign out_valid = (count != 3'd0);
  assign out_data  = mem[head];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[tail] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[tail + 2'd1] <= push1;
    end
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + push_count;
      head  <= head + {1'b0, pop};
      count <= count + {1'b0, push_count} - {2'b0, pop};
    end
  end

endmodule

`default_nettype wire

/* sv/bam_record_stream_decoder.sv */
`default_nettype none
// A result beat is written into the result queue when its byte beat is accepted and is read from the queue head.
// One stream byte per cycle while the result queue has room; a byte that yields two results
// (two bases) fills two entries of the 4-entry result queue.
// Reset: synchronous, active high; clears the parser to the header text length
// phase, clears the sticky error and sets quality_on to 1.

module bam_record_stream_decoder
  import bamrsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [7:0]  stream_byte,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        keep_quality,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       result_kind,
  output logic [30:0]      position,
  output logic [7:0]       char_value,
  output logic [15:0]      record_flag,
  output logic [30:0]      sequence_length,
  output logic             paired_input,
  output logic             last
);

  typedef enum logic [3:0] {
    PH_TEXTLEN, PH_TEXT, PH_NREF, PH_LNAME, PH_SKIP, PH_BSIZE, PH_FIXED,
    PH_DROP, PH_NAME, PH_CIGAR, PH_SEQ, PH_QUAL, PH_AUX, PH_DONE
  } phase_t;

  // Parser state
  phase_t      phase, phase_next;
  logic [31:0] byte_counter, byte_counter_next;
  logic [31:0] field_assembly, field_assembly_next;
  logic [31:0] block_remaining, block_remaining_next;
  logic [7:0]  name_length, name_length_next;
  logic [15:0] cigar_count, cigar_count_next;
  logic [15:0] current_flag, current_flag_next;
  logic [31:0] base_count, base_count_next;
  logic [31:0] item_index, item_index_next;
  logic [31:0] refs_left, refs_left_next;
  logic        quality_present, quality_present_next;
  logic        first_seen, first_seen_next;
  logic        first_bit, first_bit_next;
  logic        error_sticky, error_sticky_next;
  logic        quality_on;
  // running total of bytes a kept record needs, built during the fixed part
  logic [33:0] need_sum, need_sum_next;

  logic        in_fire;
  logic [1:0]  n_res;
  result_t     res0, res1;
  logic [1:0]  push_count;
  result_t     out_data;

  // Combinational helpers
  logic [31:0] assembled;
  logic        word_done;
  logic [31:0] item_plus1;
  logic [31:0] item_plus2;
  logic        rev;
  logic        paired;
  logic        err;
  logic        qp;
  logic [4:0]  off;
  logic [15:0] flag_word;
  result_t     done_res;

  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign assembled  = field_assembly |
                      ({24'b0, stream_byte} << {byte_counter[1:0], 3'b000});
  assign word_done  = (byte_counter[1:0] == 2'd3);
  assign item_plus1 = item_index + 32'd1;
  assign item_plus2 = item_index + 32'd2;
  assign rev        = current_flag[4];
  assign paired     = first_seen & first_bit;
  assign off        = byte_counter[4:0];
  assign flag_word  = {stream_byte, current_flag[7:0]};

  function automatic result_t mk(input logic [2:0] k, input logic [30:0] pos,
                                 input logic [7:0] ch, input logic [15:0] fl,
                                 input logic [30:0] len, input logic pr);
    result_t r;
    r.kind       = k;
    r.position   = pos;
    r.char_value = ch;
    r.flag       = fl;
    r.seq_len    = len;
    r.paired     = pr;
    r.last       = 1'b0;
    return r;
  endfunction

  // Mirror an index for reverse-strand records
  function automatic logic [30:0] mirror(input logic [31:0] idx, input logic r,
                                         input logic [31:0] bc);
    logic [31:0] m;
    m = r ? (bc - 32'd1 - idx) : idx;
    return m[30:0];
  endfunction

  function automatic logic [7:0] base_char(input logic [3:0] code, input logic r);
    logic [3:0] c;
    c = r ? {code[0], code[1], code[2], code[3]} : code;
    return base_letter(c);
  endfunction

  always_comb begin
    phase_next           = phase;
    byte_counter_next    = byte_counter;
    field_assembly_next  = field_assembly;
    block_remaining_next = block_remaining;
    name_length_next     = name_length;
    cigar_count_next     = cigar_count;
    current_flag_next    = current_flag;
    base_count_next      = base_count;
    item_index_next      = item_index;
    refs_left_next       = refs_left;
    quality_present_next = quality_present;
    first_seen_next      = first_seen;
    first_bit_next       = first_bit;
    error_sticky_next    = error_sticky;
    need_sum_next        = need_sum;
    n_res                = 2'd0;
    res0                 = '0;
    res1                 = '0;
    err                  = 1'b0;
    qp                   = quality_present;
    done_res = mk(KIND_DONE, 31'd0, 8'd0, current_flag, base_count[30:0], paired);

    if (error_sticky) begin
      res0  = mk(KIND_ERR, 31'd0, 8'd0, 16'd0, 31'd0, paired);
      n_res = 2'd1;
    end else if (phase == PH_DONE) begin
      res0  = mk(KIND_END, 31'd0, 8'd0, 16'd0, 31'd0, paired);
      n_res = 2'd1;
    end else if (kind) begin
      // end of stream is clean only on a record boundary
      if (phase == PH_BSIZE && byte_counter == 32'd0) begin
        phase_next = PH_DONE;
        res0       = mk(KIND_END, 31'd0, 8'd0, 16'd0, 31'd0, paired);
        n_res      = 2'd1;
      end else begin
        err = 1'b1;
      end
    end else begin
      case (phase)
        PH_TEXTLEN: begin
          field_assembly_next = assembled;
          byte_counter_next   = byte_counter + 32'd1;
          if (word_done) begin
            if (assembled[31]) begin
              err = 1'b1;
            end else begin
              item_index_next = '0;
              if (assembled == 32'd0) begin
                phase_next          = PH_NREF;
                byte_counter_next   = '0;
                field_assembly_next = '0;
              end else begin
                phase_next        = PH_TEXT;
                byte_counter_next = assembled;
              end
            end
          end
        end
        PH_TEXT: begin
          res0  = mk(KIND_HDR, item_index[30:0], stream_byte, 16'd0, 31'd0, paired);
          n_res = 2'd1;
          item_index_next   = item_plus1;
          byte_counter_next = byte_counter - 32'd1;
          if (byte_counter == 32'd1) begin
            phase_next          = PH_NREF;
            byte_counter_next   = '0;
            field_assembly_next = '0;
          end
        end
        PH_NREF: begin
          field_assembly_next = assembled;
          byte_counter_next   = byte_counter + 32'd1;
          if (word_done) begin
            if (assembled[31]) begin
              err = 1'b1;
            end else begin
              refs_left_next      = assembled;
              phase_next          = (assembled == 32'd0) ? PH_BSIZE : PH_LNAME;
              byte_counter_next   = '0;
              field_assembly_next = '0;
            end
          end
        end
        PH_LNAME: begin
          field_assembly_next = assembled;
          byte_counter_next   = byte_counter + 32'd1;
          if (word_done) begin
            if (assembled[31]) begin
              err = 1'b1;
            end else begin
              phase_next        = PH_SKIP;
              byte_counter_next = assembled + 32'd4;
            end
          end
        end
        PH_SKIP: begin
          byte_counter_next = byte_counter - 32'd1;
          if (byte_counter == 32'd1) begin
            refs_left_next      = refs_left - 32'd1;
            phase_next          = (refs_left == 32'd1) ? PH_BSIZE : PH_LNAME;
            byte_counter_next   = '0;
            field_assembly_next = '0;
          end
        end
        PH_BSIZE: begin
          field_assembly_next = assembled;
          byte_counter_next   = byte_counter + 32'd1;
          if (word_done) begin
            if (assembled[31] || assembled < 32'd32) begin
              err = 1'b1;
            end else begin
              block_remaining_next = assembled;
              byte_counter_next    = '0;
              phase_next           = PH_FIXED;
            end
          end
        end
        PH_FIXED: begin
          byte_counter_next    = byte_counter + 32'd1;
          block_remaining_next = block_remaining - 32'd1;
          if (off == 5'd0)  quality_present_next = 1'b0;
          if (off == 5'd8)  name_length_next = stream_byte;
          if (off == 5'd12) cigar_count_next = {8'd0, stream_byte};
          if (off == 5'd13) cigar_count_next = {stream_byte, cigar_count[7:0]};
          if (off == 5'd14) current_flag_next = {8'd0, stream_byte};
          if (off == 5'd16) base_count_next = {24'd0, stream_byte};
          if (off == 5'd17) base_count_next = {base_count[31:16], stream_byte, base_count[7:0]};
          if (off == 5'd18) base_count_next = {base_count[31:24], stream_byte, base_count[15:0]};
          if (off == 5'd19) base_count_next = {stream_byte, base_count[23:0]};
          // spread the length sum over three bytes
          if (off == 5'd20) begin
            need_sum_next = 34'd32 + {26'd0, name_length} + {16'd0, cigar_count, 2'b00};
          end
          if (off == 5'd21) need_sum_next = need_sum + {2'd0, base_count};
          if (off == 5'd22) begin
            need_sum_next = need_sum + {3'd0, base_count[31:1]} + {33'd0, base_count[0]};
          end
          if (off == 5'd15) begin
            current_flag_next = flag_word;
            if ((flag_word & FLAG_DROP_MASK) != 16'd0) begin
              phase_next = PH_DROP;
            end else if (!first_seen) begin
              first_seen_next = 1'b1;
              first_bit_next  = flag_word[0];
            end
          end
          if (off == 5'd31) begin
            if (name_length == 8'd0 || base_count[31]) begin
              err = 1'b1;
            end else if (need_sum > {2'd0, block_remaining} + 34'd31) begin
              err = 1'b1;
            end else begin
              item_index_next = '0;
              phase_next      = PH_NAME;
            end
          end
        end
        PH_DROP: begin
          block_remaining_next = block_remaining - 32'd1;
          if (block_remaining == 32'd1) begin
            phase_next          = PH_BSIZE;
            byte_counter_next   = '0;
            field_assembly_next = '0;
          end
        end
        default: begin
          case (phase)
            PH_NAME: begin
              res0  = mk(KIND_NAME, item_index[30:0],
                         (item_plus1 == {24'd0, name_length}) ? 8'd0 : stream_byte,
                         current_flag, base_count[30:0], paired);
              n_res = 2'd1;
              item_index_next = item_plus1;
              if (item_plus1 >= {24'd0, name_length}) begin
                if (cigar_count != 16'd0) begin
                  phase_next        = PH_CIGAR;
                  byte_counter_next = {14'd0, cigar_count, 2'b00};
                end else begin
                  item_index_next = '0;
                  phase_next      = (base_count != 32'd0) ? PH_SEQ : PH_AUX;
                end
              end
            end
            PH_CIGAR: begin
              byte_counter_next = byte_counter - 32'd1;
              if (byte_counter == 32'd1) begin
                item_index_next = '0;
                phase_next      = (base_count != 32'd0) ? PH_SEQ : PH_AUX;
              end
            end
            PH_SEQ: begin
              res0  = mk(KIND_BASE, mirror(item_index, rev, base_count),
                         base_char(stream_byte[7:4], rev), current_flag,
                         base_count[30:0], paired);
              n_res = 2'd1;
              item_index_next = item_plus1;
              if (item_plus1 < base_count) begin
                res1  = mk(KIND_BASE, mirror(item_plus1, rev, base_count),
                           base_char(stream_byte[3:0], rev), current_flag,
                           base_count[30:0], paired);
                n_res = 2'd2;
                item_index_next = item_plus2;
                if (item_plus2 >= base_count) begin
                  item_index_next = '0;
                  phase_next      = PH_QUAL;
                end
              end else begin
                item_index_next = '0;
                phase_next      = PH_QUAL;
              end
            end
            PH_QUAL: begin
              if (item_index == 32'd0) begin
                qp = quality_on && (stream_byte != QUAL_MISSING);
              end
              quality_present_next = qp;
              if (qp) begin
                res0  = mk(KIND_QUAL, mirror(item_index, rev, base_count),
                           stream_byte + QUAL_OFFSET, current_flag,
                           base_count[30:0], paired);
                n_res = 2'd1;
              end
              item_index_next = item_plus1;
              if (item_plus1 >= base_count) phase_next = PH_AUX;
            end
            default: begin
              // tag area: consume and drop
            end
          endcase
          block_remaining_next = block_remaining - 32'd1;
          if (block_remaining == 32'd1) begin
            if (n_res == 2'd0) begin
              res0 = done_res;
            end else begin
              res1 = done_res;
            end
            n_res               = n_res + 2'd1;
            phase_next          = PH_BSIZE;
            byte_counter_next   = '0;
            field_assembly_next = '0;
          end
        end
      endcase
    end

    if (err) begin
      error_sticky_next = 1'b1;
      res0  = mk(KIND_ERR, 31'd0, 8'd0, 16'd0, 31'd0, paired);
      n_res = 2'd1;
    end
    // mark the final result of this byte
    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

  assign push_count = in_fire ? n_res : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_TEXTLEN;
      byte_counter    <= '0;
      field_assembly  <= '0;
      block_remaining <= '0;
      name_length     <= '0;
      cigar_count     <= '0;
      current_flag    <= '0;
      base_count      <= '0;
      item_index      <= '0;
      refs_left       <= '0;
      quality_present <= 1'b0;
      first_seen      <= 1'b0;
      first_bit       <= 1'b0;
      error_sticky    <= 1'b0;
      need_sum        <= '0;
      quality_on      <= 1'b1;
    end else begin
      if (cfg_valid) begin
        quality_on <= keep_quality;
      end
      // advance the parser only on an accepted byte beat
      if (in_fire) begin
        phase           <= phase_next;
        byte_counter    <= byte_counter_next;
        field_assembly  <= field_assembly_next;
        block_remaining <= block_remaining_next;
        name_length     <= name_length_next;
        cigar_count     <= cigar_count_next;
        current_flag    <= current_flag_next;
        base_count      <= base_count_next;
        item_index      <= item_index_next;
        refs_left       <= refs_left_next;
        quality_present <= quality_present_next;
        first_seen      <= first_seen_next;
        first_bit       <= first_bit_next;
        error_sticky    <= error_sticky_next;
        need_sum        <= need_sum_next;
      end
    end
  end

  // Result queue: buffers results; the byte side waits while fewer than two entries are free
  bamrsd_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (res0),
    .push1      (res1),
    .room2      (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign result_kind     = out_data.kind;
  assign position        = out_data.position;
  assign char_value      = out_data.char_value;
  assign record_flag     = out_data.flag;
  assign sequence_length = out_data.seq_len;
  assign paired_input    = out_data.paired;
  assign last            = out_data.last;

endmodule

`default_nettype wire

/* sv/bamrsd_checker.sv */
`default_nettype none

module bamrsd_checker
  import bamrsd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  result_kind,
  input wire logic [30:0] position,
  input wire logic [7:0]  char_value,
  input wire logic [15:0] record_flag,
  input wire logic [30:0] sequence_length,
  input wire logic        last
);

  logic err_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      err_seen <= 1'b0;
    end else if (out_valid && out_ready && result_kind == KIND_ERR) begin
      err_seen <= 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && err_seen |-> result_kind == KIND_ERR)
    else $error("non-error result after an error");

  a_hdr: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_HDR |-> record_flag == 16'd0 && sequence_length == 31'd0)
    else $error("header character carries record fields");

  a_term: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_END || result_kind == KIND_ERR || result_kind == KIND_DONE)
    |-> last && position == 31'd0 && char_value == 8'd0)
    else $error("terminal result malformed");

endmodule

bind bam_record_stream_decoder bamrsd_checker u_bamrsd_checker (.*);

`default_nettype wire
